// ===== rtl/tempo_subdivision_hit_generator_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the tempo subdivision hit generator
// ---------------------------------------------------------------------------
`ifndef TEMPO_SUBDIVISION_HIT_GENERATOR_DEFINES_SVH
`define TEMPO_SUBDIVISION_HIT_GENERATOR_DEFINES_SVH

// Check a consequence in the same cycle as its cause
`define TSHG_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause
`define TSHG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tshg_pkg.sv =====
// ---------------------------------------------------------------------------
// tshg_pkg
// Shared widths, register codes and state type of the hit generator.
// ---------------------------------------------------------------------------
`default_nettype none

package tshg_pkg;

    // Field widths
    localparam int TEMPO_W     = 20;
    localparam int RATE_W      = 18;
    localparam int START_W     = 48;
    localparam int LEN_W       = 14;
    localparam int SUB_W       = 7;
    localparam int SCALE_W     = 16;

    // Configuration port
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_SUBDIV = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCALE  = 1'd1;
    localparam logic [SUB_W-1:0]   SUB_RESET   = 7'd1;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

    // Samples per minute scale: 60 seconds times 1000 for milli-bpm
    localparam int RATE_SCALE_W = 16;
    localparam logic [RATE_SCALE_W-1:0] RATE_SCALE = 16'd60000;
    localparam int NUM_BASE_W  = RATE_SCALE_W + RATE_W;
    localparam int DEN_W       = TEMPO_W + SUB_W;

    // Parameter defaults
    localparam int MAX_HITS_DEF  = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_CHECK,
        FR_DIV_P,
        FR_MOD_GO,
        FR_DIV_M,
        FR_CNT_GO,
        FR_DIV_C,
        FR_PUSH
    } front_state_t;

endpackage

`default_nettype wire

// ===== rtl/tshg_div.sv =====
// ---------------------------------------------------------------------------
// tshg_div
// Restoring divider, one quotient bit per cycle; dividend comes MSB-aligned.
// ---------------------------------------------------------------------------
`default_nettype none

module tshg_div #(
    parameter int QW = 64,
    parameter int PW = 50,
    parameter int SW = $clog2(QW + 1)
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [QW-1:0] dividend,
    input  wire logic [PW-1:0] divisor,
    input  wire logic [SW-1:0] steps,
    output logic               done,
    output logic [QW-1:0]      quotient,
    output logic [PW-1:0]      remainder
);

    logic [QW-1:0] q_reg, q_next;
    logic [PW-1:0] r_reg, r_next;
    logic [PW-1:0] d_reg, d_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;

    logic [PW:0]   trial;
    logic [PW:0]   diff;
    logic          ge;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        trial = {r_reg, q_reg[QW-1]};
        diff  = trial - {1'b0, d_reg};
        ge    = (trial >= {1'b0, d_reg});
    end

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
            cnt_next = steps;
            run_next = 1'b1;
        end else if (run_reg) begin
            q_next   = {q_reg[QW-2:0], ge};
            r_next   = ge ? diff[PW-1:0] : trial[PW-1:0];
            cnt_next = cnt_reg - SW'(1);
            if (cnt_reg == SW'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

`default_nettype wire

// ===== rtl/tshg_front.sv =====
// ---------------------------------------------------------------------------
// tshg_front
// Accept a buffer, derive period, first hit offset and hit count.
// ---------------------------------------------------------------------------
`default_nettype none

module tshg_front #(
    parameter int FRAC_BITS = tshg_pkg::FRAC_BITS_DEF,
    parameter int MAX_HITS  = tshg_pkg::MAX_HITS_DEF,
    parameter int OW        = tshg_pkg::LEN_W + FRAC_BITS,
    parameter int IW        = $clog2(MAX_HITS + 1)
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [tshg_pkg::TEMPO_W-1:0] s_tempo_milli_bpm,
    input  wire logic [tshg_pkg::RATE_W-1:0]  s_rate_hz,
    input  wire logic [tshg_pkg::START_W-1:0] s_start_sample,
    input  wire logic [tshg_pkg::LEN_W-1:0]   s_buffer_length,
    input  wire logic [tshg_pkg::SUB_W-1:0]   subdivision,
    output logic                              push,
    input  wire logic                         full,
    output logic [tshg_pkg::START_W-1:0]      job_start,
    output logic [OW-1:0]                     job_first,
    output logic [OW-1:0]                     job_period,
    output logic [IW-1:0]                     job_last_idx,
    output logic                              job_trunc
);

    localparam int PW = tshg_pkg::NUM_BASE_W + FRAC_BITS;
    localparam int QW = tshg_pkg::START_W + FRAC_BITS;
    localparam int SW = $clog2(QW + 1);

    tshg_pkg::front_state_t state_reg, state_next;

    logic [tshg_pkg::START_W-1:0]    start_reg, start_next;
    logic [tshg_pkg::LEN_W-1:0]      len_reg, len_next;
    logic [tshg_pkg::DEN_W-1:0]      den_reg, den_next;
    logic [tshg_pkg::NUM_BASE_W-1:0] num_reg, num_next;
    logic [PW-1:0]                   period_reg, period_next;
    logic [PW-1:0]                   first_reg, first_next;
    logic [IW-1:0]                   last_idx_reg, last_idx_next;
    logic                            trunc_reg, trunc_next;

    logic          div_start;
    logic [QW-1:0] div_dividend;
    logic [PW-1:0] div_divisor;
    logic [SW-1:0] div_steps;
    logic          div_done;
    logic [QW-1:0] div_quot;
    logic [PW-1:0] div_rem;

    logic          accept;
    logic [OW-1:0] limit;
    logic [OW-1:0] span;
    logic          no_work;
    logic          no_period;
    logic          no_hit;
    logic          over;

    // Conditions that end a buffer with no hits, and the hit-count overflow check
    always_comb begin
        accept    = s_valid && s_ready;
        limit     = {len_reg, FRAC_BITS'(0)};
        span      = limit - OW'(1) - first_reg[OW-1:0];
        no_work   = (den_reg == '0) || (len_reg == '0);
        no_period = (period_reg == '0);
        no_hit    = (first_reg >= PW'(limit));
        over      = (div_quot >= QW'(MAX_HITS));
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tshg_pkg::FR_IDLE: begin
                if (s_valid) state_next = tshg_pkg::FR_CHECK;
            end
            tshg_pkg::FR_CHECK: begin
                state_next = no_work ? tshg_pkg::FR_IDLE : tshg_pkg::FR_DIV_P;
            end
            tshg_pkg::FR_DIV_P: begin
                if (div_done) state_next = tshg_pkg::FR_MOD_GO;
            end
            tshg_pkg::FR_MOD_GO: begin
                state_next = no_period ? tshg_pkg::FR_IDLE : tshg_pkg::FR_DIV_M;
            end
            tshg_pkg::FR_DIV_M: begin
                if (div_done) state_next = tshg_pkg::FR_CNT_GO;
            end
            tshg_pkg::FR_CNT_GO: begin
                state_next = no_hit ? tshg_pkg::FR_IDLE : tshg_pkg::FR_DIV_C;
            end
            tshg_pkg::FR_DIV_C: begin
                if (div_done) state_next = tshg_pkg::FR_PUSH;
            end
            tshg_pkg::FR_PUSH: begin
                if (!full) state_next = tshg_pkg::FR_IDLE;
            end
            default: state_next = tshg_pkg::FR_IDLE;
        endcase
    end

    // Outputs: handshake and divider launches
    always_comb begin
        s_ready      = 1'b0;
        push         = 1'b0;
        div_start    = 1'b0;
        div_dividend = {num_reg, (QW - tshg_pkg::NUM_BASE_W)'(0)};
        div_divisor  = PW'(den_reg);
        div_steps    = SW'(PW);
        case (state_reg)
            tshg_pkg::FR_IDLE: begin
                s_ready = 1'b1;
            end
            tshg_pkg::FR_CHECK: begin
                div_start = !no_work;
            end
            tshg_pkg::FR_MOD_GO: begin
                div_start    = !no_period;
                div_dividend = {start_reg, FRAC_BITS'(0)};
                div_divisor  = period_reg;
                div_steps    = SW'(QW);
            end
            tshg_pkg::FR_CNT_GO: begin
                div_start    = !no_hit;
                div_dividend = {span, (QW - OW)'(0)};
                div_divisor  = period_reg;
                div_steps    = SW'(OW);
            end
            tshg_pkg::FR_PUSH: begin
                push = !full;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Datapath registers
    always_comb begin
        start_next    = start_reg;
        len_next      = len_reg;
        den_next      = den_reg;
        num_next      = num_reg;
        period_next   = period_reg;
        first_next    = first_reg;
        last_idx_next = last_idx_reg;
        trunc_next    = trunc_reg;
        if (accept) begin
            start_next = s_start_sample;
            len_next   = s_buffer_length;
            den_next   = s_tempo_milli_bpm * subdivision;
            num_next   = tshg_pkg::RATE_SCALE * s_rate_hz;
        end
        if (div_done) begin
            case (state_reg)
                tshg_pkg::FR_DIV_P: begin
                    period_next = div_quot[PW-1:0];
                end
                tshg_pkg::FR_DIV_M: begin
                    first_next = (div_rem == '0) ? '0 : period_reg - div_rem;
                end
                tshg_pkg::FR_DIV_C: begin
                    trunc_next    = over;
                    last_idx_next = over ? IW'(MAX_HITS - 1) : div_quot[IW-1:0];
                end
                default: begin
                    trunc_next = trunc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tshg_pkg::FR_IDLE;
        end else begin
            state_reg <= state_next;
        end
        start_reg    <= start_next;
        len_reg      <= len_next;
        den_reg      <= den_next;
        num_reg      <= num_next;
        period_reg   <= period_next;
        first_reg    <= first_next;
        last_idx_reg <= last_idx_next;
        trunc_reg    <= trunc_next;
    end

    tshg_div #(
        .QW (QW),
        .PW (PW),
        .SW (SW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .steps     (div_steps),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Offsets of emitted hits stay below the limit, so the low bits suffice
    assign job_start    = start_reg;
    assign job_first    = first_reg[OW-1:0];
    assign job_period   = period_reg[OW-1:0];
    assign job_last_idx = last_idx_reg;
    assign job_trunc    = trunc_reg;

endmodule

`default_nettype wire

// ===== rtl/tshg_fifo.sv =====
// ---------------------------------------------------------------------------
// tshg_fifo
// Small descriptor queue between the front and back parts.
// ---------------------------------------------------------------------------
`default_nettype none

module tshg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tshg_pkg::QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wptr_reg, wptr_next;
    logic [AW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    // Advance pointers and occupancy
    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push) begin
            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
        end
        if (pop) begin
            rptr_next = (rptr_reg == AW'(DEPTH - 1)) ? '0 : rptr_reg + AW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
        if (push) begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    assign full  = (cnt_reg == CW'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem_reg[rptr_reg];

endmodule

`default_nettype wire

// ===== rtl/tshg_back.sv =====
// ---------------------------------------------------------------------------
// tshg_back
// Walk the hits of one buffer and present one result per cycle while m_ready is high.
// ---------------------------------------------------------------------------
`default_nettype none

module tshg_back #(
    parameter int FRAC_BITS = tshg_pkg::FRAC_BITS_DEF,
    parameter int OW        = tshg_pkg::LEN_W + FRAC_BITS,
    parameter int IW        = 7
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         empty,
    output logic                              pop,
    input  wire logic [tshg_pkg::START_W-1:0] job_start,
    input  wire logic [OW-1:0]                job_first,
    input  wire logic [OW-1:0]                job_period,
    input  wire logic [IW-1:0]                job_last_idx,
    input  wire logic                         job_trunc,
    input  wire logic [tshg_pkg::SCALE_W-1:0] scale,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [tshg_pkg::START_W-1:0]      m_hit_position,
    output logic [tshg_pkg::SCALE_W-1:0]      m_hit_value,
    output logic                              m_last_hit,
    output logic                              m_truncated
);

    localparam logic [OW:0] HALF = (OW + 1)'(1) << (FRAC_BITS - 1);

    logic                         busy_reg, busy_next;
    logic [tshg_pkg::START_W-1:0] start_reg, start_next;
    logic [OW-1:0]                off_reg, off_next;
    logic [OW-1:0]                per_reg, per_next;
    logic [IW-1:0]                k_reg, k_next;
    logic [IW-1:0]                last_reg, last_next;
    logic                         trunc_reg, trunc_next;

    logic                         xfer;
    logic                         final_hit;
    logic [OW:0]                  rounded;

    always_comb begin
        xfer      = busy_reg && m_ready;
        final_hit = (k_reg == last_reg);
        pop       = !empty && (!busy_reg || (xfer && final_hit));
    end

    // Load a new buffer, step to the next hit, or drop to idle
    always_comb begin
        busy_next  = busy_reg;
        start_next = start_reg;
        off_next   = off_reg;
        per_next   = per_reg;
        k_next     = k_reg;
        last_next  = last_reg;
        trunc_next = trunc_reg;
        if (pop) begin
            busy_next  = 1'b1;
            start_next = job_start;
            off_next   = job_first;
            per_next   = job_period;
            k_next     = '0;
            last_next  = job_last_idx;
            trunc_next = job_trunc;
        end else if (xfer && final_hit) begin
            busy_next = 1'b0;
        end else if (xfer) begin
            off_next = off_reg + per_reg;
            k_next   = k_reg + IW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        start_reg <= start_next;
        off_reg   <= off_next;
        per_reg   <= per_next;
        k_reg     <= k_next;
        last_reg  <= last_next;
        trunc_reg <= trunc_next;
    end

    // Round the fixed-point offset to the nearest sample, halves up
    always_comb begin
        rounded        = {1'b0, off_reg} + HALF;
        m_hit_position = start_reg + tshg_pkg::START_W'(rounded[OW:FRAC_BITS]);
    end

    assign m_valid     = busy_reg;
    assign m_hit_value = scale;
    assign m_last_hit  = final_hit;
    assign m_truncated = trunc_reg;

endmodule

`default_nettype wire

// ===== rtl/tempo_subdivision_hit_generator.sv =====
// ---------------------------------------------------------------------------
// tempo_subdivision_hit_generator
// Emits subdivision hit positions for each audio buffer.
// ---------------------------------------------------------------------------
// Each accepted buffer item yields zero to MAX_HITS results, one per hit,
// in increasing position order; last_hit marks the final one and truncated
// is set on every result of a buffer that had more hits than MAX_HITS. The
// front part works through one buffer at a time on a single restoring
// divider that produces one bit per cycle; it derives the period, then the
// first-hit remainder, then the hit count, with control states for accept,
// check, the two divider launches and the push, which waits while the queue
// is full. A buffer with no work, no period or no hit goes back to idle
// early. The back part then emits one hit per cycle while m_ready is high. A
// two-entry descriptor queue sits between them, so the arithmetic for the
// next buffer overlaps the emission of the current one. Configuration
// writes must be issued while the block is idle.
// ---------------------------------------------------------------------------
`default_nettype none

`include "tempo_subdivision_hit_generator_defines.svh"

module tempo_subdivision_hit_generator #(
    parameter int MAX_HITS  = tshg_pkg::MAX_HITS_DEF,
    parameter int FRAC_BITS = tshg_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [tshg_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [tshg_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [tshg_pkg::TEMPO_W-1:0]    s_tempo_milli_bpm,
    input  wire logic [tshg_pkg::RATE_W-1:0]     s_rate_hz,
    input  wire logic [tshg_pkg::START_W-1:0]    s_start_sample,
    input  wire logic [tshg_pkg::LEN_W-1:0]      s_buffer_length,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [tshg_pkg::START_W-1:0]         m_hit_position,
    output logic [tshg_pkg::SCALE_W-1:0]         m_hit_value,
    output logic                                 m_last_hit,
    output logic                                 m_truncated
);

    localparam int OW = tshg_pkg::LEN_W + FRAC_BITS;
    localparam int IW = $clog2(MAX_HITS + 1);
    localparam int DW = tshg_pkg::START_W + 2 * OW + IW + 1;

    logic [tshg_pkg::SUB_W-1:0]   sub_reg, sub_next;
    logic [tshg_pkg::SCALE_W-1:0] scale_reg, scale_next;

    logic                         q_push;
    logic                         q_full;
    logic                         q_pop;
    logic                         q_empty;
    logic [DW-1:0]                q_wdata;
    logic [DW-1:0]                q_rdata;

    logic [tshg_pkg::START_W-1:0] f_start, b_start;
    logic [OW-1:0]                f_first, b_first;
    logic [OW-1:0]                f_period, b_period;
    logic [IW-1:0]                f_last, b_last;
    logic                         f_trunc, b_trunc;

    // Configuration registers
    always_comb begin
        sub_next   = sub_reg;
        scale_next = scale_reg;
        if (cfg_we) begin
            case (cfg_addr)
                tshg_pkg::CFG_SUBDIV: sub_next   = cfg_wdata[tshg_pkg::SUB_W-1:0];
                tshg_pkg::CFG_SCALE:  scale_next = cfg_wdata[tshg_pkg::SCALE_W-1:0];
                default:              sub_next   = sub_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg   <= tshg_pkg::SUB_RESET;
            scale_reg <= tshg_pkg::SCALE_RESET;
        end else begin
            sub_reg   <= sub_next;
            scale_reg <= scale_next;
        end
    end

    tshg_front #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_HITS  (MAX_HITS),
        .OW        (OW),
        .IW        (IW)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_tempo_milli_bpm (s_tempo_milli_bpm),
        .s_rate_hz         (s_rate_hz),
        .s_start_sample    (s_start_sample),
        .s_buffer_length   (s_buffer_length),
        .subdivision       (sub_reg),
        .push              (q_push),
        .full              (q_full),
        .job_start         (f_start),
        .job_first         (f_first),
        .job_period        (f_period),
        .job_last_idx      (f_last),
        .job_trunc         (f_trunc)
    );

    // Pack and unpack the buffer descriptor
    assign q_wdata = {f_start, f_first, f_period, f_last, f_trunc};
    assign {b_start, b_first, b_period, b_last, b_trunc} = q_rdata;

    tshg_fifo #(
        .WIDTH (DW),
        .DEPTH (tshg_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .empty   (q_empty)
    );

    tshg_back #(
        .FRAC_BITS (FRAC_BITS),
        .OW        (OW),
        .IW        (IW)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .empty          (q_empty),
        .pop            (q_pop),
        .job_start      (b_start),
        .job_first      (b_first),
        .job_period     (b_period),
        .job_last_idx   (b_last),
        .job_trunc      (b_trunc),
        .scale          (scale_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit_position (m_hit_position),
        .m_hit_value    (m_hit_value),
        .m_last_hit     (m_last_hit),
        .m_truncated    (m_truncated)
    );

    // Queue is never written while full
    `TSHG_ASSERT_SAME(a_queue_no_overflow, aclk, aresetn, q_push, !q_full, "push into full queue")
    // A buffer's hits leave back to back until the last one
    `TSHG_ASSERT_NEXT(a_burst_continues, aclk, aresetn, m_valid && m_ready && !m_last_hit, m_valid, "gap inside a hit burst")
    // The truncation flag holds across all hits of one buffer
    `TSHG_ASSERT_NEXT(a_trunc_steady, aclk, aresetn, m_valid && m_ready && !m_last_hit, m_truncated == $past(m_truncated), "truncation flag changed inside a burst")

endmodule

`default_nettype wire
